[sv/rfde_pkg.sv]
// shared types and constants of the rotated framebuffer draw engine
`default_nettype none
package rfde_pkg;

    // coordinate width, wide enough for glyph corners far off screen
    localparam int CW = 11;
    localparam int SCALE_W = 5;
    localparam int GLYPH_BITS = 40;
    localparam int GIDX_W = 6;
    localparam int INDEX_W = 9;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_RECT  = 2'd1,
        OP_GLYPH = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // classified command as it travels from front to back
    typedef struct packed {
        op_t                   op;
        logic [CW-1:0]         x0;
        logic [CW-1:0]         y0;
        logic [CW-1:0]         w;
        logic [CW-1:0]         h;
        logic                  on;
        logic [GLYPH_BITS-1:0] glyph;
        logic [SCALE_W-1:0]    scale;
        logic [INDEX_W-1:0]    idx;
        logic                  skip;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GLYPH,
        ST_RD,
        ST_WR,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic boot;
        logic idle;
    } status_t;

endpackage
`default_nettype wire

[sv/rfde_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module rfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[sv/rfde_front.sv]
// front end: accepts commands and classifies them for the back end
`default_nettype none
module rfde_front #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_PAGES = 4,
    parameter int MAX_SCALE = 8
) (
    input  wire logic [1:0]          op,
    input  wire logic [4:0]          pos_x,
    input  wire logic [6:0]          pos_y,
    input  wire logic [5:0]          rect_width,
    input  wire logic [7:0]          rect_height,
    input  wire logic                pixel_on,
    input  wire logic [39:0]         glyph_bits,
    input  wire logic [3:0]          glyph_scale,
    input  wire logic [8:0]          byte_index,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                q_full,
    input  wire logic                boot,
    output logic                     push,
    output rfde_pkg::cmd_t           cmd
);
    import rfde_pkg::*;

    localparam int STORE_SIZE = SCREEN_PAGES * SCREEN_COLUMNS;

    logic [SCALE_W-1:0] scale_sat;
    logic               y_off;

    // no transfer during the clearing pass after reset
    assign in_ready = !q_full && !boot;
    assign push = in_valid && in_ready;

    // saturate the glyph scale
    assign scale_sat = (SCALE_W'(glyph_scale) > SCALE_W'(MAX_SCALE)) ?
                       SCALE_W'(MAX_SCALE) : SCALE_W'(glyph_scale);
    assign y_off = int'(pos_y) >= SCREEN_COLUMNS;

    // build the command and flag those that touch nothing
    always_comb
    begin
        cmd.op = op_t'(op);
        cmd.x0 = CW'(pos_x);
        cmd.y0 = CW'(pos_y);
        cmd.w = CW'(rect_width);
        cmd.h = CW'(rect_height);
        cmd.on = pixel_on;
        cmd.glyph = glyph_bits;
        cmd.scale = scale_sat;
        cmd.idx = byte_index;
        case (op_t'(op))
            OP_RECT:  cmd.skip = (rect_width == 6'd0) || (rect_height == 8'd0) || y_off;
            OP_GLYPH: cmd.skip = (scale_sat == '0) || y_off;
            OP_READ:  cmd.skip = int'(byte_index) >= STORE_SIZE;
            default:  cmd.skip = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

[sv/rfde_queue.sv]
// two entry command queue between front and back
`default_nettype none
module rfde_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  rfde_pkg::cmd_t      push_cmd,
    input  wire logic           pop,
    output logic                full,
    output logic                q_valid,
    output rfde_pkg::cmd_t      q_cmd
);
    import rfde_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_cmd = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule
`default_nettype wire

[sv/rfde_back.sv]
// back end: byte read-modify-write sequencer over the frame store
`default_nettype none
module rfde_back #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_PAGES = 4,
    parameter int GLYPH_COLUMNS = 5
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  rfde_pkg::cmd_t      q_cmd,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          read_byte,
    output logic [1:0]          done_op,
    output rfde_pkg::status_t   status
);
    import rfde_pkg::*;

    localparam int DEPTH = SCREEN_PAGES * SCREEN_COLUMNS;
    localparam int AW = $clog2(DEPTH);
    localparam int PW = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
    localparam int GCW = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
    localparam int ROWS = 8 * SCREEN_PAGES;

    state_t          state_reg, state_next;
    logic            boot_reg, boot_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    cmd_t            cmd_reg, cmd_next;
    logic [CW-1:0]   rx0_reg, rx0_next;
    logic [CW-1:0]   rw_reg, rw_next;
    logic [CW-1:0]   yend_reg, yend_next;
    logic [CW-1:0]   y_reg, y_next;
    logic [PW-1:0]   p_reg, p_next;
    logic            ron_reg, ron_next;
    logic [7:0]      mask_reg, mask_next;
    logic [GCW-1:0]  gcol_reg, gcol_next;
    logic [2:0]      grow_reg, grow_next;
    logic [7:0]      rd_byte_reg, rd_byte_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    logic [1:0]      out_op_reg, out_op_next;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr, addr_c;
    logic [7:0]      ram_wdata, ram_rdata;
    logic [7:0]      mask_c;
    logic            last_page, last_row, glyph_on;
    logic [GIDX_W-1:0] gidx;
    logic [CW-1:0]   gx0, gy0, y_inc;

    rfde_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // byte address and per-bit mask of the current page and column
    assign addr_c = AW'(int'(p_reg) * SCREEN_COLUMNS + int'(y_reg));
    always_comb
    begin
        logic [CW-1:0] xk;
        for (int k = 0; k < 8; k++)
        begin
            xk = CW'(ROWS - 1) - CW'(int'(p_reg) * 8 + k);
            mask_c[k] = (xk >= rx0_reg) && (xk < CW'(rx0_reg + rw_reg));
        end
    end

    assign y_inc = CW'(y_reg + CW'(1));
    assign last_page = int'(p_reg) == SCREEN_PAGES - 1;
    assign last_row = (y_inc == yend_reg) || (int'(y_inc) >= SCREEN_COLUMNS);

    // current glyph pixel and the corner of its scaled square
    assign gidx = GIDX_W'(int'(gcol_reg) * 8 + int'(grow_reg));
    assign glyph_on = (int'(gidx) < GLYPH_BITS) ? cmd_reg.glyph[gidx] : 1'b0;
    assign gx0 = CW'(cmd_reg.x0 + CW'(gcol_reg) * CW'(cmd_reg.scale));
    assign gy0 = CW'(cmd_reg.y0 + CW'(grow_reg) * CW'(cmd_reg.scale));

    // next state and datapath
    always_comb
    begin
        logic advance;
        logic finish;
        state_next = state_reg;
        boot_next = boot_reg;
        cnt_next = cnt_reg;
        cmd_next = cmd_reg;
        rx0_next = rx0_reg;
        rw_next = rw_reg;
        yend_next = yend_reg;
        y_next = y_reg;
        p_next = p_reg;
        ron_next = ron_reg;
        mask_next = mask_reg;
        gcol_next = gcol_reg;
        grow_next = grow_reg;
        rd_byte_next = rd_byte_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next = out_byte_reg;
        out_op_next = out_op_reg;
        advance = 1'b0;
        finish = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = AW'(cnt_reg + AW'(1));
                if (int'(cnt_reg) == DEPTH - 1)
                begin
                    boot_next = 1'b0;
                    state_next = boot_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next = q_cmd;
                    rd_byte_next = 8'd0;
                    if (q_cmd.skip)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        case (q_cmd.op)
                            OP_CLEAR:
                            begin
                                cnt_next = '0;
                                state_next = ST_CLEAR;
                            end
                            OP_RECT:
                            begin
                                rx0_next = q_cmd.x0;
                                rw_next = q_cmd.w;
                                yend_next = CW'(q_cmd.y0 + q_cmd.h);
                                y_next = q_cmd.y0;
                                p_next = '0;
                                ron_next = q_cmd.on;
                                state_next = ST_RD;
                            end
                            OP_GLYPH:
                            begin
                                gcol_next = '0;
                                grow_next = '0;
                                state_next = ST_GLYPH;
                            end
                            default:
                            begin
                                state_next = ST_READ;
                            end
                        endcase
                    end
                end
            end
            ST_GLYPH:
            begin
                if (int'(gy0) >= SCREEN_COLUMNS)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    rx0_next = gx0;
                    rw_next = CW'(cmd_reg.scale);
                    yend_next = CW'(gy0 + CW'(cmd_reg.scale));
                    y_next = gy0;
                    p_next = '0;
                    ron_next = glyph_on;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (mask_c == 8'd0)
                begin
                    advance = 1'b1;
                end
                else
                begin
                    mask_next = mask_c;
                    state_next = ST_WR;
                end
            end
            ST_WR:
            begin
                advance = 1'b1;
            end
            ST_READ:
            begin
                rd_byte_next = ram_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next = rd_byte_reg;
                    out_op_next = cmd_reg.op;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // step to the next page, then the next column of the area
        if (advance)
        begin
            state_next = ST_RD;
            if (!last_page)
            begin
                p_next = PW'(p_reg + PW'(1));
            end
            else if (!last_row)
            begin
                p_next = '0;
                y_next = y_inc;
            end
            else
            begin
                finish = 1'b1;
            end
        end

        // area done: next glyph pixel or end of command
        if (finish)
        begin
            if (cmd_reg.op == OP_GLYPH)
            begin
                state_next = ST_GLYPH;
                if (grow_reg == 3'd7)
                begin
                    grow_next = '0;
                    if (int'(gcol_reg) == GLYPH_COLUMNS - 1)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        gcol_next = GCW'(gcol_reg + GCW'(1));
                    end
                end
                else
                begin
                    grow_next = grow_reg + 3'd1;
                end
            end
            else
            begin
                state_next = ST_DONE;
            end
        end
    end

    // store port controls and queue pop
    always_comb
    begin
        pop = (state_reg == ST_IDLE) && q_valid;
        ram_we = (state_reg == ST_CLEAR) || (state_reg == ST_WR);
        ram_waddr = (state_reg == ST_CLEAR) ? cnt_reg : addr_c;
        ram_wdata = (state_reg == ST_CLEAR) ? 8'd0 :
                    ((ram_rdata & ~mask_reg) | (ron_reg ? mask_reg : 8'd0));
        ram_re = ((state_reg == ST_RD) && (mask_c != 8'd0)) ||
                 (pop && (q_cmd.op == OP_READ) && !q_cmd.skip);
        ram_raddr = (state_reg == ST_IDLE) ? AW'(q_cmd.idx) : addr_c;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            boot_reg <= 1'b1;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            boot_reg <= boot_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        rx0_reg <= rx0_next;
        rw_reg <= rw_next;
        yend_reg <= yend_next;
        y_reg <= y_next;
        p_reg <= p_next;
        ron_reg <= ron_next;
        mask_reg <= mask_next;
        gcol_reg <= gcol_next;
        grow_reg <= grow_next;
        rd_byte_reg <= rd_byte_next;
        out_byte_reg <= out_byte_next;
        out_op_reg <= out_op_next;
    end

    assign out_valid = out_valid_reg;
    assign read_byte = out_byte_reg;
    assign done_op = out_op_reg;
    assign status.boot = boot_reg;
    assign status.idle = state_reg == ST_IDLE;
endmodule
`default_nettype wire

[sv/rotated_framebuffer_draw_engine.sv]
// A read fetches one byte, a clear zeroes the whole store and a command that touches
// nothing goes straight to its result; rect and glyph read-modify-write each page byte
// with pixels in the area over every column touched, glyph once per glyph pixel.
// One command is worked at a time; a two entry queue takes the next ones.
// Reset: clearing pass over the whole store with in_ready low.
// top level of the rotated framebuffer draw engine
`default_nettype none
module rotated_framebuffer_draw_engine #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_PAGES = 4,
    parameter int GLYPH_COLUMNS = 5,
    parameter int MAX_SCALE = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [4:0]  pos_x,
    input  wire logic [6:0]  pos_y,
    input  wire logic [5:0]  rect_width,
    input  wire logic [7:0]  rect_height,
    input  wire logic        pixel_on,
    input  wire logic [39:0] glyph_bits,
    input  wire logic [3:0]  glyph_scale,
    input  wire logic [8:0]  byte_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       read_byte,
    output logic [1:0]       done_op
);
    import rfde_pkg::*;

    cmd_t    push_cmd, q_cmd;
    logic    push, pop, q_full, q_valid;
    status_t status;

    rfde_front #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_PAGES   (SCREEN_PAGES),
        .MAX_SCALE      (MAX_SCALE)
    ) u_front (
        .op          (op),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .pixel_on    (pixel_on),
        .glyph_bits  (glyph_bits),
        .glyph_scale (glyph_scale),
        .byte_index  (byte_index),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .q_full      (q_full),
        .boot        (status.boot),
        .push        (push),
        .cmd         (push_cmd)
    );

    rfde_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    rfde_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_PAGES   (SCREEN_PAGES),
        .GLYPH_COLUMNS  (GLYPH_COLUMNS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_byte (read_byte),
        .done_op   (done_op),
        .status    (status)
    );

    // no transfer accepted during the clearing pass
    a_boot_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        status.boot |-> !in_ready)
        else $error("input accepted during clearing pass");

    // only reads return a nonzero byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (done_op != OP_READ)) |-> (read_byte == 8'd0))
        else $error("nonzero byte on a non-read result");

    // the clearing pass after reset produces no result
    a_boot_silent: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(status.boot) |-> !out_valid)
        else $error("result after reset clearing pass");

    // nothing is pulled from the queue while the back end is busy
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (status.idle && q_valid))
        else $error("queue popped outside idle");
endmodule
`default_nettype wire

[dv/tb_rotated_framebuffer_draw_engine.sv]
// testbench for the rotated framebuffer draw engine: directed and random commands checked against a pixel model
`timescale 1ns / 1ps
`default_nettype none
module tb_rotated_framebuffer_draw_engine;
    import rfde_pkg::*;

    localparam int COLS = 128;
    localparam int PAGES = 4;
    localparam int LAND_X = 8 * PAGES;
    localparam int FB_BYTES = PAGES * COLS;
    localparam int LIMIT_CYCLES = 20000000;

    typedef struct {
        logic [7:0] rd;
        op_t        op;
    } done_t;

    // frame store mirror and queue of expected completions
    class draw_scoreboard;
        logic [7:0] fb [FB_BYTES];
        done_t      waiting [$];
        int         errors;

        function new();
            foreach (fb[i]) fb[i] = 8'h00;
            errors = 0;
        endfunction

        function void plot(int x, int y, bit on);
            int r;
            int addr;
            if (x >= LAND_X || y >= COLS) return;
            r = LAND_X - 1 - x;
            addr = (r / 8) * COLS + y;
            fb[addr][r % 8] = on;
        endfunction

        // apply one accepted command and queue its completion
        function void note_command(op_t o, int x, int y, int w, int h, bit on,
                                   logic [39:0] g, int sc, int idx);
            done_t d;
            int s;
            d.op = o;
            d.rd = 8'h00;
            case (o)
                OP_CLEAR: foreach (fb[i]) fb[i] = 8'h00;
                OP_RECT:
                    for (int i = 0; i < w; i++)
                        for (int j = 0; j < h; j++)
                            plot(x + i, y + j, on);
                OP_GLYPH:
                begin
                    s = (sc > 8) ? 8 : sc;
                    for (int c = 0; c < 5; c++)
                        for (int r = 0; r < 8; r++)
                            for (int a = 0; a < s; a++)
                                for (int b = 0; b < s; b++)
                                    plot(x + c * s + a, y + r * s + b, g[c * 8 + r]);
                end
                default: if (idx < FB_BYTES) d.rd = fb[idx];
            endcase
            waiting.push_back(d);
        endfunction

        function void check_result(logic [7:0] rd, logic [1:0] o);
            done_t d;
            if (waiting.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected completion: op %0d byte %02h", o, rd);
                return;
            end
            d = waiting.pop_front();
            if (rd !== d.rd || o !== d.op)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected op %0d byte %02h, got op %0d byte %02h",
                             d.op, d.rd, o, rd);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [4:0]  pos_x;
    logic [6:0]  pos_y;
    logic [5:0]  rect_width;
    logic [7:0]  rect_height;
    logic        pixel_on;
    logic [39:0] glyph_bits;
    logic [3:0]  glyph_scale;
    logic [8:0]  byte_index;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_byte;
    logic [1:0]  done_op;

    draw_scoreboard sb;
    int  cycles;
    bit  no_idle;

    rotated_framebuffer_draw_engine u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .pos_x(pos_x), .pos_y(pos_y),
        .rect_width(rect_width), .rect_height(rect_height),
        .pixel_on(pixel_on), .glyph_bits(glyph_bits),
        .glyph_scale(glyph_scale), .byte_index(byte_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .read_byte(read_byte), .done_op(done_op)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // result side stalls
    always @(negedge clk)
    begin
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 30);
    end

    // result check on each output transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(read_byte, done_op);
    end

    // run guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[rotated_framebuffer_draw_engine] ERROR");
            $finish;
        end
    end

    // one command transfer, with random idle cycles ahead of it
    task automatic send_cmd(op_t o, int x, int y, int w, int h, bit on,
                            logic [39:0] g, int sc, int idx);
        bit taken;
        taken = 1'b0;
        while (!no_idle && $urandom_range(99) < 30)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        op = o;
        pos_x = 5'(x);
        pos_y = 7'(y);
        rect_width = 6'(w);
        rect_height = 8'(h);
        pixel_on = on;
        glyph_bits = g;
        glyph_scale = 4'(sc);
        byte_index = 9'(idx);
        in_valid = 1'b1;
        while (!taken)
        begin
            @(posedge clk);
            taken = in_ready;
            @(negedge clk);
        end
        sb.note_command(o, int'(pos_x), int'(pos_y), int'(rect_width), int'(rect_height),
                        on, g, int'(glyph_scale), int'(byte_index));
        in_valid = 1'b0;
    endtask

    task automatic send_random();
        int pick;
        int w;
        int h;
        int sc;
        logic [39:0] g;
        pick = $urandom_range(99);
        g = 40'({$urandom, $urandom});
        if ($urandom_range(9) == 0)
        begin
            w = $urandom_range(63);
            h = $urandom_range(255);
            sc = $urandom_range(15);
        end
        else
        begin
            w = $urandom_range(8);
            h = $urandom_range(16);
            sc = $urandom_range(3);
        end
        if (pick < 3)
            send_cmd(OP_CLEAR, $urandom_range(31), $urandom_range(127), w, h,
                     $urandom_range(1), g, sc, $urandom_range(511));
        else if (pick < 38)
            send_cmd(OP_RECT, $urandom_range(31), $urandom_range(127), w, h,
                     $urandom_range(1), g, sc, $urandom_range(511));
        else if (pick < 60)
            send_cmd(OP_GLYPH, $urandom_range(31), $urandom_range(127), w, h,
                     $urandom_range(1), g, sc, $urandom_range(511));
        else
            send_cmd(OP_READ, $urandom_range(31), $urandom_range(127), w, h,
                     $urandom_range(1), g, sc, $urandom_range(511));
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        op = OP_CLEAR;
        pos_x = '0;
        pos_y = '0;
        rect_width = '0;
        rect_height = '0;
        pixel_on = 1'b0;
        glyph_bits = '0;
        glyph_scale = '0;
        byte_index = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, empty shapes, clipping, scale limits
        send_cmd(OP_READ, 0, 0, 0, 0, 0, '0, 0, 0);
        send_cmd(OP_RECT, 0, 0, 32, 128, 1, '0, 0, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, '0, 0, 511);
        send_cmd(OP_RECT, 3, 5, 0, 40, 0, '0, 0, 0);
        send_cmd(OP_RECT, 3, 5, 20, 0, 0, '0, 0, 0);
        send_cmd(OP_RECT, 31, 127, 63, 255, 0, '0, 0, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, '0, 0, 127);
        send_cmd(OP_RECT, 10, 60, 1, 1, 0, '1, 15, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, '0, 0, 2 * COLS + 60);
        send_cmd(OP_CLEAR, 31, 127, 63, 255, 1, '1, 15, 511);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, '0, 0, 0);
        send_cmd(OP_GLYPH, 0, 0, 0, 0, 0, '1, 0, 0);
        send_cmd(OP_GLYPH, 0, 0, 0, 0, 0, 40'hA5_5A_FF_00_81, 1, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, '0, 0, 3 * COLS + 2);
        send_cmd(OP_GLYPH, 2, 10, 0, 0, 0, '1, 8, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, '0, 0, 2 * COLS + 20);
        send_cmd(OP_GLYPH, 9, 30, 0, 0, 0, 40'h12_34_56_78_9A, 15, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, '0, 0, COLS + 40);
        send_cmd(OP_GLYPH, 31, 127, 63, 255, 1, '1, 8, 511);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, '0, 0, 127);
        send_cmd(OP_GLYPH, 0, 0, 0, 0, 0, '0, 8, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, '0, 0, 3 * COLS + 10);

        // random commands, with one stretch free of idle cycles
        for (int n = 0; n < 1330; n++)
        begin
            no_idle = (n >= 600 && n < 800);
            send_random();
        end
        no_idle = 1'b0;

        while (sb.waiting.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("[rotated_framebuffer_draw_engine] OK");
        else
            $display("[rotated_framebuffer_draw_engine] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
